FILE: hdl/ssc_pkg.sv
package ssc_pkg;

    localparam int unsigned PermDepth = 256;

    localparam logic KIND_KEY  = 1'b0;
    localparam logic KIND_DATA = 1'b1;

    typedef enum logic [3:0] {
        ST_FILL,
        ST_IDLE,
        ST_RD_J,
        ST_RD_I,
        ST_RD_JN,
        ST_SWAP_I,
        ST_SWAP_J,
        ST_RD_B,
        ST_RD_Z,
        ST_FIN,
        ST_PUT,
        ST_KEY_SN,
        ST_KEY_WR_N,
        ST_KEY_WR_J
    } state_t;

    // One write request to the permutation memory.
    typedef struct packed {
        logic       we;
        logic [7:0] addr;
        logic [7:0] data;
    } perm_wr_t;

endpackage

FILE: hdl/spritz_style_stream_cipher.sv
// Data byte: the result is registered into m_tdata after the request is accepted (and
// the output is free); no new request is taken before then, a pace set by the
// chain of dependent reads on the single read port of the permutation memory.
// Key byte: stored, input stays ready. The final key byte starts the key schedule.
// Synchronous active-low reset; after reset a fill loads the identity permutation
// before the first request is accepted. Step writes (cfg_wr_en) are taken always.
module spritz_style_stream_cipher
    import ssc_pkg::*;
#(
    parameter int unsigned MAX_KEY_BYTES = 256
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] data_byte
    input  logic       s_tuser,    // [0] kind
    input  logic       s_tlast,    // key_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata     // [7:0] out_byte
);

    localparam int unsigned KeyAw  = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam logic [8:0]  MaxKey = 9'(MAX_KEY_BYTES);

    state_t     state_reg, state_next;
    logic [7:0] n_reg, n_next;
    logic [7:0] m_reg, m_next;
    logic [8:0] len_reg, len_next;
    logic [8:0] key_count_reg, key_count_next;
    logic [7:0] i_reg, i_next;
    logic [7:0] j_reg, j_next;
    logic [7:0] k_reg, k_next;
    logic [7:0] z_reg, z_next;
    logic [7:0] t_reg, t_next;
    logic [7:0] s_reg, s_next;
    logic [7:0] data_reg, data_next;
    logic [7:0] w_reg;
    logic       sched_reg, sched_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic [7:0] m_tdata_reg, m_tdata_next;

    perm_wr_t   perm_wr;
    logic [7:0] perm_raddr;
    logic [7:0] perm_rdata;

    logic [7:0] key_mem [MAX_KEY_BYTES];
    logic [7:0] key_rdata_reg;
    logic       key_we;
    logic       s_fire;
    logic       out_free;
    logic [8:0] count_inc;

    ssc_perm_mem u_perm (
        .aclk  (aclk),
        .wr    (perm_wr),
        .raddr (perm_raddr),
        .rdata (perm_rdata)
    );

    always_ff @(posedge aclk) begin
        if (key_we) begin
            key_mem[key_count_reg[KeyAw-1:0]] <= s_tdata;
        end
        key_rdata_reg <= key_mem[m_next[KeyAw-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_reg <= 8'd1;
        end else if (cfg_wr_en) begin
            w_reg <= cfg_wr_data | 8'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_FILL;
            n_reg         <= '0;
            m_reg         <= '0;
            len_reg       <= 9'd1;
            key_count_reg <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            z_reg         <= '0;
            sched_reg     <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            m_reg         <= m_next;
            len_reg       <= len_next;
            key_count_reg <= key_count_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            z_reg         <= z_next;
            sched_reg     <= sched_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        t_reg       <= t_next;
        s_reg       <= s_next;
        data_reg    <= data_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign count_inc = key_count_reg + 9'd1;

    always_comb begin
        state_next     = state_reg;
        n_next         = n_reg;
        m_next         = m_reg;
        len_next       = len_reg;
        key_count_next = key_count_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        z_next         = z_reg;
        t_next         = t_reg;
        s_next         = s_reg;
        data_next      = data_reg;
        sched_next     = sched_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        perm_wr        = '0;
        perm_raddr     = j_reg;
        key_we         = 1'b0;

        case (state_reg)
            ST_FILL: begin
                perm_wr.we   = 1'b1;
                perm_wr.addr = n_reg;
                perm_wr.data = n_reg;
                perm_raddr   = 8'd0;
                m_next       = '0;
                if (n_reg == 8'd255) begin
                    n_next = '0;
                    j_next = '0;
                    state_next = sched_reg ? ST_KEY_SN : ST_IDLE;
                end else begin
                    n_next = n_reg + 8'd1;
                end
            end
            ST_IDLE: begin
                if (s_fire) begin
                    data_next = s_tdata;
                    if (s_tuser == KIND_DATA) begin
                        state_next = ST_RD_J;
                    end else begin
                        // A full key store drops the byte; the final byte still
                        // starts the schedule.
                        if (key_count_reg < MaxKey) begin
                            key_we         = 1'b1;
                            key_count_next = count_inc;
                        end
                        if (s_tlast) begin
                            if (key_count_reg < MaxKey) begin
                                len_next = count_inc;
                            end else if (key_count_reg == '0) begin
                                len_next = 9'd1;
                            end else begin
                                len_next = key_count_reg;
                            end
                            key_count_next = '0;
                            n_next         = '0;
                            sched_next     = 1'b1;
                            state_next     = ST_FILL;
                        end
                    end
                end
            end
            ST_RD_J: begin
                perm_raddr = j_reg;
                i_next     = i_reg + w_reg;
                state_next = ST_RD_I;
            end
            ST_RD_I: begin
                t_next     = perm_rdata;
                perm_raddr = i_reg;
                state_next = ST_RD_JN;
            end
            ST_RD_JN: begin
                s_next     = perm_rdata;
                j_next     = k_reg + t_reg + perm_rdata;
                perm_raddr = j_next;
                state_next = ST_SWAP_I;
            end
            ST_SWAP_I: begin
                k_next       = k_reg + i_reg + perm_rdata;
                perm_wr.we   = 1'b1;
                perm_wr.addr = i_reg;
                perm_wr.data = perm_rdata;
                state_next   = ST_SWAP_J;
            end
            ST_SWAP_J: begin
                perm_wr.we   = 1'b1;
                perm_wr.addr = j_reg;
                perm_wr.data = s_reg;
                perm_raddr   = z_reg + k_reg;
                state_next   = ST_RD_B;
            end
            ST_RD_B: begin
                perm_raddr = i_reg + perm_rdata;
                state_next = ST_RD_Z;
            end
            ST_RD_Z: begin
                perm_raddr = j_reg + perm_rdata;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                z_next = perm_rdata;
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = perm_rdata ^ data_reg;
                    state_next    = ST_IDLE;
                end else begin
                    state_next = ST_PUT;
                end
            end
            ST_PUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = z_reg ^ data_reg;
                    state_next    = ST_IDLE;
                end
            end
            ST_KEY_SN: begin
                s_next     = perm_rdata;
                j_next     = j_reg + perm_rdata + key_rdata_reg;
                perm_raddr = j_next;
                state_next = ST_KEY_WR_N;
            end
            ST_KEY_WR_N: begin
                perm_wr.we   = 1'b1;
                perm_wr.addr = n_reg;
                perm_wr.data = perm_rdata;
                state_next   = ST_KEY_WR_J;
            end
            ST_KEY_WR_J: begin
                perm_wr.we   = 1'b1;
                perm_wr.addr = j_reg;
                perm_wr.data = s_reg;
                perm_raddr   = n_reg + 8'd1;
                if ((9'(m_reg) + 9'd1) == len_reg) begin
                    m_next = '0;
                end else begin
                    m_next = m_reg + 8'd1;
                end
                if (n_reg == 8'd255) begin
                    i_next     = '0;
                    j_next     = '0;
                    k_next     = '0;
                    z_next     = '0;
                    sched_next = 1'b0;
                    state_next = ST_IDLE;
                end else begin
                    n_next     = n_reg + 8'd1;
                    state_next = ST_KEY_SN;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

FILE: hdl/ssc_perm_mem.sv
module ssc_perm_mem
    import ssc_pkg::*;
(
    input  logic       aclk,
    input  perm_wr_t   wr,
    input  logic [7:0] raddr,
    output logic [7:0] rdata
);

    logic [7:0] mem [PermDepth];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (wr.we) begin
            mem[wr.addr] <= wr.data;
        end
    end

    // A read of the entry being written in the same cycle returns the new value.
    always_ff @(posedge aclk) begin
        if (wr.we && (wr.addr == raddr)) begin
            rdata_reg <= wr.data;
        end else begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/ssc_checker.sv
module ssc_checker
    import ssc_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic       s_tuser,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // A waiting result holds until it is taken.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // A data request keeps the block busy while its result is computed.
    a_data_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == KIND_DATA) |=> !s_tready ##1 !s_tready)
        else $error("input ready during a data step");

    // A plain key byte is only stored, so the block is ready again at once.
    a_key_fast: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == KIND_KEY) && !s_tlast |=> s_tready)
        else $error("key byte stalled the input");

    // The final key byte starts the schedule, which blocks the input.
    a_sched_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == KIND_KEY) && s_tlast |=> !s_tready)
        else $error("input ready during key schedule");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !s_tready)
        else $error("channel active after reset");

endmodule

bind spritz_style_stream_cipher ssc_checker u_ssc_checker (.*);

FILE: tb/ssc_cipher_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the cipher, keeps its own copy of the permutation
// state and compares every output byte with the predicted ciphertext.
module ssc_cipher_checker
    import ssc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tuser,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    output int unsigned error_count,
    output int unsigned results_checked,
    output int unsigned pending_results
);

    localparam int unsigned KeyCap = 256;

    logic [7:0]  perm [PermDepth];
    logic [7:0]  key_mem [PermDepth];
    int unsigned key_len;
    logic [7:0]  idx_i;
    logic [7:0]  idx_j;
    logic [7:0]  idx_k;
    logic [7:0]  prev_z;
    logic [7:0]  step_reg;
    logic [7:0]  expected_cipher [$];

    task automatic report_error(input string what);
        $display("ERROR at %0t ns: %s", $time, what);
        error_count++;
    endtask

    always @(posedge aclk) begin : predict_and_check
        int unsigned n;
        int unsigned span;
        logic [7:0]  jj;
        logic [7:0]  tmp;
        logic [7:0]  w;
        logic [7:0]  addr;
        logic [7:0]  a;
        logic [7:0]  b;
        logic [7:0]  z;
        logic [7:0]  want;

        if (!aresetn) begin
            for (n = 0; n < PermDepth; n++) begin
                perm[n]    = n[7:0];
                key_mem[n] = 8'h00;
            end
            key_len         = 0;
            idx_i           = 8'h00;
            idx_j           = 8'h00;
            idx_k           = 8'h00;
            prev_z          = 8'h00;
            step_reg        = 8'h01;
            error_count     = 0;
            results_checked = 0;
            expected_cipher.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_cipher.size() == 0) begin
                    report_error($sformatf("result 0x%02h with no request waiting", m_tdata));
                end else begin
                    want = expected_cipher.pop_front();
                    results_checked++;
                    if (m_tdata !== want) begin
                        report_error($sformatf("out_byte 0x%02h, expected 0x%02h",
                                               m_tdata, want));
                    end
                end
            end

            if (cfg_wr_en) begin
                step_reg = cfg_wr_data;
            end

            if (s_tvalid && s_tready) begin
                if (s_tuser == KIND_DATA) begin
                    w     = step_reg | 8'h01;
                    idx_i = idx_i + w;
                    idx_j = idx_k + perm[idx_j] + perm[idx_i];
                    idx_k = idx_k + idx_i + perm[idx_j];
                    tmp         = perm[idx_i];
                    perm[idx_i] = perm[idx_j];
                    perm[idx_j] = tmp;
                    addr   = prev_z + idx_k;
                    a      = perm[addr];
                    addr   = idx_i + a;
                    b      = perm[addr];
                    addr   = idx_j + b;
                    z      = perm[addr];
                    prev_z = z;
                    expected_cipher.push_back(z ^ s_tdata);
                end else begin
                    // Bytes beyond the store's capacity are dropped, but a
                    // last marker on them still starts the schedule.
                    if (key_len < KeyCap) begin
                        key_mem[key_len[7:0]] = s_tdata;
                        key_len++;
                    end
                    if (s_tlast) begin
                        span = (key_len == 0) ? 1 : key_len;
                        for (n = 0; n < PermDepth; n++) begin
                            perm[n] = n[7:0];
                        end
                        jj = 8'h00;
                        for (n = 0; n < PermDepth; n++) begin
                            jj       = jj + perm[n] + key_mem[n % span];
                            tmp      = perm[n];
                            perm[n]  = perm[jj];
                            perm[jj] = tmp;
                        end
                        idx_i   = 8'h00;
                        idx_j   = 8'h00;
                        idx_k   = 8'h00;
                        prev_z  = 8'h00;
                        key_len = 0;
                    end
                end
            end
        end
        pending_results <= expected_cipher.size();
    end

endmodule

FILE: tb/spritz_style_stream_cipher_tb.sv
`timescale 1ns / 1ps

module spritz_style_stream_cipher_tb;
    import ssc_pkg::*;

    // The longest quiet stretch is the key schedule plus the settle wait.
    localparam int unsigned IdleLimit    = 8000;
    localparam int unsigned SettleCycles = 1100;
    localparam int unsigned PhaseItems   = 150;

    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       cfg_wr_en   = 1'b0;
    logic [7:0] cfg_wr_data = 8'h00;
    logic       s_tvalid    = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata     = 8'h00;
    logic       s_tuser     = KIND_KEY;
    logic       s_tlast     = 1'b0;
    logic       m_tvalid;
    logic       m_tready    = 1'b0;
    logic [7:0] m_tdata;

    int unsigned error_count;
    int unsigned results_checked;
    int unsigned pending_results;
    int unsigned requests_sent;
    int unsigned keys_loaded;
    int unsigned idle_cycles;
    bit          no_gaps;
    bit          long_hold_req;

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    spritz_style_stream_cipher uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    ssc_cipher_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .error_count     (error_count),
        .results_checked (results_checked),
        .pending_results (pending_results)
    );

    // Each call starts and ends at a falling edge, so a back-to-back request
    // keeps s_tvalid high without lowering it in between.
    task automatic send_item(input logic kind, input logic [7:0] value, input logic last);
        int unsigned gap;
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55) begin
            gap = 0;
        end else if (r < 90) begin
            gap = $urandom_range(1, 3);
        end else begin
            gap = $urandom_range(8, 40);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= value;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        requests_sent++;
    endtask

    task automatic send_key(input int unsigned len);
        int unsigned n;
        for (n = 0; n < len; n++) begin
            send_item(KIND_KEY, 8'($urandom), n == len - 1);
        end
        keys_loaded++;
    endtask

    task automatic send_data(input int unsigned count);
        repeat (count) send_item(KIND_DATA, 8'($urandom), 1'($urandom_range(0, 1)));
    endtask

    // Waits for every result, then for a possible key schedule to finish.
    task automatic drain_and_settle();
        s_tvalid <= 1'b0;
        while (pending_results != 0) @(negedge aclk);
        repeat (SettleCycles) @(negedge aclk);
    endtask

    task automatic write_step(input logic [7:0] value);
        drain_and_settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic random_phase(input int unsigned count);
        int unsigned target;
        int unsigned r;
        target = requests_sent + count;
        while (requests_sent < target) begin
            r       = $urandom_range(0, 99);
            no_gaps = ($urandom_range(0, 4) == 0);
            if (r < 70) begin
                // Now and then a key long enough that it may overflow the store.
                if ($urandom_range(0, 29) == 0) begin
                    send_key($urandom_range(250, 262));
                end else begin
                    send_key($urandom_range(1, 16));
                end
                send_data($urandom_range(4, 30));
            end else if (r < 85) begin
                send_data($urandom_range(1, 20));
            end else begin
                repeat ($urandom_range(1, 8)) begin
                    send_item(1'($urandom_range(0, 1)), 8'($urandom),
                              $urandom_range(0, 4) == 0);
                end
            end
        end
        no_gaps = 1'b0;
    endtask

    // Receiver: random ready with short stalls, free-running stretches, and
    // one long hold when the sender asks for it.
    initial begin : receiver
        int unsigned stall_left;
        int unsigned free_left;
        int unsigned r;
        stall_left = 0;
        free_left  = 0;
        forever begin
            @(negedge aclk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall_left    = 400;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (free_left > 0) begin
                free_left--;
                m_tready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 3) begin
                    stall_left = $urandom_range(10, 60);
                    m_tready <= 1'b0;
                end else if (r < 6) begin
                    free_left = $urandom_range(50, 300);
                    m_tready <= 1'b1;
                end else begin
                    m_tready <= ($urandom_range(0, 3) != 0);
                end
            end
        end
    end

    initial begin : watchdog
        idle_cycles = 0;
        while (idle_cycles < IdleLimit) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Timeout: no request accepted for %0d cycles", IdleLimit);
        $display("Mismatches found");
        $finish;
    end

    initial begin : stimulus
        logic [7:0] steps [8];
        int unsigned p;
        steps[0] = 8'd0;
        steps[1] = 8'd2;
        steps[2] = 8'd128;
        steps[3] = 8'($urandom);
        steps[4] = 8'($urandom);
        steps[5] = 8'd1;
        steps[6] = 8'($urandom);
        steps[7] = 8'($urandom);
        requests_sent = 0;
        keys_loaded   = 0;
        no_gaps       = 1'b0;
        long_hold_req = 1'b0;

        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Data on the reset permutation with the reset step; the last marker
        // on a data byte must be ignored.
        send_item(KIND_DATA, 8'h00, 1'b0);
        send_item(KIND_DATA, 8'hFF, 1'b1);
        send_item(KIND_DATA, 8'h5A, 1'b0);
        // Zero key bytes are ordinary key bytes.
        send_item(KIND_KEY, 8'h00, 1'b0);
        send_item(KIND_KEY, 8'h00, 1'b0);
        send_item(KIND_KEY, 8'hFF, 1'b1);
        send_item(KIND_DATA, 8'hFF, 1'b0);
        send_item(KIND_DATA, 8'h00, 1'b1);
        // Single-byte keys at both extremes.
        send_item(KIND_KEY, 8'hFF, 1'b1);
        send_data(2);
        send_item(KIND_KEY, 8'h00, 1'b1);
        send_data(2);
        // A key interrupted by data keeps collecting afterwards.
        send_item(KIND_KEY, 8'h12, 1'b0);
        send_item(KIND_DATA, 8'h34, 1'b0);
        send_item(KIND_KEY, 8'h56, 1'b1);
        send_data(2);

        write_step(8'd255);
        send_item(KIND_KEY, 8'hA5, 1'b1);
        send_data(4);

        for (p = 0; p < 8; p++) begin
            write_step(steps[p]);
            if (p == 1) begin
                // Long receiver hold while requests keep coming.
                long_hold_req = 1'b1;
                no_gaps       = 1'b1;
                send_data(12);
                no_gaps       = 1'b0;
            end
            if (p == 2) begin
                send_key(260);
                send_data(8);
            end
            random_phase(PhaseItems);
        end

        drain_and_settle();
        $display("Run covered %0d requests and %0d keys over steps 1, 255, 0, 2, 128 and random.",
                 requests_sent, keys_loaded);
        $display("%0d cipher bytes compared, %0d errors.", results_checked, error_count);
        if (error_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: files.f
hdl/ssc_pkg.sv
hdl/ssc_perm_mem.sv
hdl/spritz_style_stream_cipher.sv
hdl/ssc_checker.sv
tb/ssc_cipher_checker.sv
tb/spritz_style_stream_cipher_tb.sv
